// ===== src/abe_pkg.sv =====
// ----------------------------------------------------------------------------
// abe_pkg: shared types and constants of the arithmetic block encoder
// Field widths, register indexes, reset bounds and the cumulative bound lookup.
// ----------------------------------------------------------------------------
package abe_pkg;

  // payload widths
  localparam int SYM_W      = 3;
  localparam int COUNT_W    = 4;
  localparam int BOUND_W    = 16;
  localparam int CUM_W      = BOUND_W + 1;
  localparam int CODE_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // alphabet size limits
  localparam logic [COUNT_W-1:0] ALPHABET_MIN   = 4'd2;
  localparam logic [COUNT_W-1:0] ALPHABET_MAX   = 4'd8;
  localparam logic [COUNT_W-1:0] ALPHABET_RESET = 4'd8;

  // cumulative bound of 1.0
  localparam logic [CUM_W-1:0] BOUND_FULL = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_SEVEN  = 3'd7;

  typedef logic [7:1][BOUND_W-1:0] bound_set_t;
  typedef logic [CUM_W-1:0]        cum_t;

  localparam bound_set_t BOUND_RESET = {
    16'd57344, 16'd49152, 16'd40960, 16'd32768, 16'd24576, 16'd16384, 16'd8192
  };

  // one classified symbol: its two cumulative bounds and the range error
  typedef struct packed {
    cum_t lo_bound;
    cum_t hi_bound;
    logic bad;
  } abe_op_t;

  // a queue slot offered from one side to the other
  typedef struct packed {
    logic    valid;
    abe_op_t op;
  } abe_push_t;

  // cumulative bound before symbol k for an alphabet of cnt symbols
  function automatic cum_t cum_bound(input logic [COUNT_W-1:0] k,
                                     input logic [COUNT_W-1:0] cnt,
                                     input bound_set_t bounds);
    cum_t res;
    res = '0;
    if (k == '0) begin
      res = '0;
    end else if (k >= cnt) begin
      res = BOUND_FULL;
    end else begin
      res = {1'b0, bounds[k[2:0]]};
    end
    return res;
  endfunction

endpackage

// ===== src/abe_if.sv =====
// ----------------------------------------------------------------------------
// abe_if: channel interfaces of the arithmetic block encoder
// Symbol input, codeword result and configuration write channels.
// ----------------------------------------------------------------------------

// symbol channel
interface abe_sym_if;
  logic                     valid;
  logic                     ready;
  logic [abe_pkg::SYM_W-1:0] symbol_index;

  modport source (output valid, output symbol_index, input ready);
  modport sink   (input valid, input symbol_index, output ready);
endinterface

// codeword channel
interface abe_code_if;
  logic                      valid;
  logic                      ready;
  logic [abe_pkg::CODE_W-1:0] codeword;
  logic                      bad_symbol;

  modport source (output valid, output codeword, output bad_symbol, input ready);
  modport sink   (input valid, input codeword, input bad_symbol, output ready);
endinterface

// configuration write channel
interface abe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [abe_pkg::CFG_IDX_W-1:0]  index;
  logic [abe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/arithmetic_block_encoder_top.sv =====
// ----------------------------------------------------------------------------
// arithmetic_block_encoder_top: fixed-point arithmetic coding encoder
// Narrows an interval per symbol and emits the midpoint code per message.
//
//   channel  dir  payload                      transfer when
//   in_if    in   symbol_index[2:0]            valid && ready
//   out_if   out  codeword[31:0], bad_symbol   valid && ready
//   cfg_if   in   index[2:0], data[15:0]       valid && ready (ready tied high)
//
// one symbol per cycle sustained unless the last symbol of a message waits on
// a busy finished stage; the interval loop (two 49x17 multiplies, add and
// compare) updates on each pop in the back stage; a codeword passes through
// the finished interval stage and result register once its last symbol pops
// rst_n is synchronous: interval, counters and configuration return to reset
// out_ready low holds the result; the queue absorbs two symbols before
// in_if.ready drops
// ----------------------------------------------------------------------------
module arithmetic_block_encoder_top #(
  parameter int MESSAGE_LENGTH = 8,
  parameter int CODE_BITS      = 32,
  parameter int FRACTION_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  abe_sym_if.sink     in_if,
  abe_code_if.source  out_if,
  abe_cfg_if.sink     cfg_if
);

  abe_pkg::abe_push_t push;
  abe_pkg::abe_push_t head;
  logic               q_full;
  logic               pop;

  // classification front
  abe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .push   (push)
  );

  // decoupling queue
  abe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // interval back end
  abe_back #(
    .MESSAGE_LENGTH (MESSAGE_LENGTH),
    .CODE_BITS      (CODE_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

// ===== src/abe_front.sv =====
// ----------------------------------------------------------------------------
// abe_front: configuration registers and symbol classification
// Clamps each symbol to the alphabet and looks up its two cumulative bounds.
// ----------------------------------------------------------------------------
module abe_front (
  input  logic               clk,
  input  logic               rst_n,
  abe_sym_if.sink            in_if,
  abe_cfg_if.sink            cfg_if,
  input  logic               q_full,
  output abe_pkg::abe_push_t push
);

  logic [abe_pkg::COUNT_W-1:0] symbol_count_r;
  abe_pkg::bound_set_t         bounds_r;

  logic [abe_pkg::COUNT_W-1:0] count_eff;
  logic [abe_pkg::COUNT_W-1:0] sym_ext;
  logic [abe_pkg::COUNT_W-1:0] sym_clamped;
  logic                        sym_bad;

  // configuration writes, always taken
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= abe_pkg::ALPHABET_RESET;
      bounds_r       <= abe_pkg::BOUND_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index) inside
        abe_pkg::REG_SYMBOL_COUNT: begin
          symbol_count_r <= cfg_if.data[abe_pkg::COUNT_W-1:0];
        end
        [abe_pkg::REG_BOUND_ONE:abe_pkg::REG_BOUND_SEVEN]: begin
          bounds_r[cfg_if.index] <= cfg_if.data;
        end
        default: begin
          symbol_count_r <= symbol_count_r;
        end
      endcase
    end
  end

  // effective alphabet size and symbol clamp
  always_comb begin
    count_eff = symbol_count_r;
    if (symbol_count_r < abe_pkg::ALPHABET_MIN) count_eff = abe_pkg::ALPHABET_MIN;
    if (symbol_count_r > abe_pkg::ALPHABET_MAX) count_eff = abe_pkg::ALPHABET_MAX;
    sym_ext     = abe_pkg::COUNT_W'(in_if.symbol_index);
    sym_clamped = sym_ext;
    sym_bad     = 1'b0;
    if (sym_ext >= count_eff) begin
      sym_clamped = count_eff - 4'd1;
      sym_bad     = 1'b1;
    end
  end

  // classified item into the queue
  assign in_if.ready      = !q_full;
  assign push.valid       = in_if.valid && !q_full;
  assign push.op.lo_bound = abe_pkg::cum_bound(sym_clamped, count_eff, bounds_r);
  assign push.op.hi_bound = abe_pkg::cum_bound(sym_clamped + 4'd1, count_eff, bounds_r);
  assign push.op.bad      = sym_bad;

endmodule

// ===== src/abe_queue.sv =====
// ----------------------------------------------------------------------------
// abe_queue: short queue between front and back
// Two-entry first-in first-out store of classified symbols.
// ----------------------------------------------------------------------------
module abe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  abe_pkg::abe_push_t push,
  input  logic               pop,
  output logic               full,
  output abe_pkg::abe_push_t head
);

  abe_pkg::abe_op_t            slot_r [abe_pkg::QUEUE_DEPTH];
  logic [abe_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [abe_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [abe_pkg::QCNT_W-1:0]  count_r;
  logic [abe_pkg::QCNT_W-1:0]  count_nxt;
  logic                        do_pop;

  assign full   = (count_r == abe_pkg::QCNT_W'(abe_pkg::QUEUE_DEPTH));
  assign do_pop = pop && (count_r != '0);

  // payload slots
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.op;
    end
  end

  // pointers and fill count
  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) count_nxt = count_r + 1'b1;
    if (!push.valid && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)     rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.op    = slot_r[rd_ptr_r];

endmodule

// ===== src/abe_back.sv =====
// ----------------------------------------------------------------------------
// abe_back: interval narrowing and codeword output
// Narrows interval one symbol a cycle on pop; forms the midpoint codeword.
// ----------------------------------------------------------------------------
module abe_back #(
  parameter int MESSAGE_LENGTH = 8,
  parameter int CODE_BITS      = 32,
  parameter int FRACTION_BITS  = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abe_pkg::abe_push_t head,
  output logic               pop,
  abe_code_if.source         out_if
);

  localparam int IW     = FRACTION_BITS + 1;
  localparam int PW     = IW + abe_pkg::CUM_W;
  localparam int CNT_W  = $clog2(MESSAGE_LENGTH + 1);
  localparam int WIDE_W = IW + 48;
  localparam int SHR    = (CODE_BITS <= FRACTION_BITS) ? FRACTION_BITS - CODE_BITS : 0;
  localparam int SHL    = (CODE_BITS > FRACTION_BITS) ? CODE_BITS - FRACTION_BITS : 0;
  localparam logic [IW-1:0]     ONE      = IW'(1) << FRACTION_BITS;
  localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(MESSAGE_LENGTH - 1);
  localparam logic [WIDE_W-1:0] CODE_MASK = (WIDE_W'(1) << CODE_BITS) - WIDE_W'(1);

  // interval state
  logic [IW-1:0]    start_r, start_nxt;
  logic [IW-1:0]    end_r, end_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             err_r;

  // finished message waiting for the codeword stage
  logic             done_valid_r;
  logic [IW-1:0]    done_start_r;
  logic [IW-1:0]    done_end_r;
  logic             done_bad_r;

  // result register
  logic                        out_valid_r;
  logic [abe_pkg::CODE_W-1:0]  out_code_r;
  logic                        out_bad_r;

  logic          is_last;
  logic          out_free;
  logic          done_move;
  logic          done_free;
  logic          err_acc;
  logic [IW-1:0] width;
  logic [PW-1:0] prod_lo;
  logic [PW-1:0] prod_hi;
  logic [IW-1:0] mid;
  logic [WIDE_W-1:0] code_wide;

  // flow control through the two output stages
  assign out_free  = !out_valid_r || out_if.ready;
  assign done_move = done_valid_r && out_free;
  assign done_free = !done_valid_r || done_move;
  assign is_last   = (cnt_r == LAST_CNT);
  assign pop       = head.valid && (!is_last || done_free);
  assign err_acc   = err_r || head.op.bad;

  // narrowed interval
  always_comb begin
    width     = end_r - start_r;
    prod_lo   = PW'(width) * PW'(head.op.lo_bound);
    prod_hi   = PW'(width) * PW'(head.op.hi_bound);
    start_nxt = start_r + IW'(prod_lo >> abe_pkg::BOUND_W);
    end_nxt   = start_r + IW'(prod_hi >> abe_pkg::BOUND_W);
    if (end_nxt < start_nxt) end_nxt = start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= ONE;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (pop) begin
      if (is_last) begin
        start_r <= '0;
        end_r   <= ONE;
        cnt_r   <= '0;
        err_r   <= 1'b0;
      end else begin
        start_r <= start_nxt;
        end_r   <= end_nxt;
        cnt_r   <= cnt_r + 1'b1;
        err_r   <= err_acc;
      end
    end
  end

  // finished interval stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_valid_r <= 1'b0;
    end else if (pop && is_last) begin
      done_valid_r <= 1'b1;
    end else if (done_move) begin
      done_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_last) begin
      done_start_r <= start_nxt;
      done_end_r   <= end_nxt;
      done_bad_r   <= err_acc;
    end
  end

  // midpoint and leading code bits
  always_comb begin
    mid       = done_start_r + ((done_end_r - done_start_r) >> 1);
    code_wide = ((WIDE_W'(mid) >> SHR) << SHL) & CODE_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= done_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (done_move) begin
      out_code_r <= code_wide[abe_pkg::CODE_W-1:0];
      out_bad_r  <= done_bad_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.codeword   = out_code_r;
  assign out_if.bad_symbol = out_bad_r;

  // interval stays ordered and within one
  a_interval_order: assert property (@(posedge clk) disable iff (!rst_n)
    (start_r <= end_r) && (end_r <= ONE))
    else $error("interval out of order");

  // last symbol of a message fills the finished stage and restarts the count
  a_last_fills_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_last) |=> (done_valid_r && (cnt_r == '0) && !err_r))
    else $error("message end not captured");

  // a blocked finished interval is never overwritten
  a_done_held: assert property (@(posedge clk) disable iff (!rst_n)
    (done_valid_r && !out_free) |=> (done_valid_r && $stable(done_start_r)
                                     && $stable(done_end_r)))
    else $error("finished interval lost");

  // symbol count never passes the message length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_CNT)
    else $error("symbol count out of range");

endmodule

// ===== tb/sv/abe_code_checker.sv =====
// ----------------------------------------------------------------------------
// abe_code_checker: codeword predictor and scoreboard for the block encoder
// Watches the symbol, configuration and codeword channels, narrows its own
// fixed-point interval per accepted symbol and compares every codeword
// transfer against the oldest predicted one.
// ----------------------------------------------------------------------------
module abe_code_checker #(
  parameter int MESSAGE_LENGTH = 8,
  parameter int CODE_BITS      = 32,
  parameter int FRACTION_BITS  = 48
) (
  input  logic clk,
  input  logic rst_n,
  abe_sym_if   sym_ch,
  abe_code_if  code_ch,
  abe_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   symbols_taken,
  output int   codes_taken,
  output int   flagged_codes
);

  localparam int PROD_W = FRACTION_BITS + 18;

  typedef struct {
    logic [abe_pkg::CODE_W-1:0] codeword;
    logic                       bad_symbol;
  } code_word_t;

  // predicted codewords, oldest first
  code_word_t codes_due[$];

  // shadow configuration
  logic [abe_pkg::COUNT_W-1:0] alphabet_reg;
  abe_pkg::bound_set_t         bound_reg;

  // shadow interval and message state
  logic [FRACTION_BITS:0] ivl_lo;
  logic [FRACTION_BITS:0] ivl_hi;
  int                     msg_symbols;
  logic                   msg_bad;

  initial begin
    fail_count    = 0;
    pending       = 0;
    symbols_taken = 0;
    codes_taken   = 0;
    flagged_codes = 0;
  end

  // cumulative bound below symbol k, 1.0 at and above the alphabet size
  function automatic abe_pkg::cum_t cum_at(input int k, input int cnt);
    abe_pkg::cum_t res;
    if (k == 0) begin
      res = '0;
    end else if (k >= cnt) begin
      res = abe_pkg::BOUND_FULL;
    end else begin
      res = {1'b0, bound_reg[k]};
    end
    return res;
  endfunction

  task automatic restart_message();
    ivl_lo      = '0;
    ivl_hi      = '0;
    ivl_hi[FRACTION_BITS] = 1'b1;
    msg_symbols = 0;
    msg_bad     = 1'b0;
  endtask

  // narrow the interval by one symbol; close the message when it is full
  task automatic narrow_interval(input logic [abe_pkg::SYM_W-1:0] raw);
    int                       cnt;
    int                       sym;
    logic [FRACTION_BITS:0]   span;
    logic [FRACTION_BITS:0]   nlo;
    logic [FRACTION_BITS:0]   nhi;
    logic [FRACTION_BITS:0]   mid;
    logic [PROD_W-1:0]        plo;
    logic [PROD_W-1:0]        phi;
    logic [63:0]              code;
    code_word_t               due;
    cnt = int'(alphabet_reg);
    if (cnt < int'(abe_pkg::ALPHABET_MIN)) cnt = int'(abe_pkg::ALPHABET_MIN);
    if (cnt > int'(abe_pkg::ALPHABET_MAX)) cnt = int'(abe_pkg::ALPHABET_MAX);
    sym = int'(raw);
    // out of range symbols clamp to the last one and mark the message
    if (sym >= cnt) begin
      sym     = cnt - 1;
      msg_bad = 1'b1;
    end
    span = ivl_hi - ivl_lo;
    plo  = PROD_W'(span) * PROD_W'(cum_at(sym, cnt));
    phi  = PROD_W'(span) * PROD_W'(cum_at(sym + 1, cnt));
    nlo  = ivl_lo + plo[FRACTION_BITS+16:16];
    nhi  = ivl_lo + phi[FRACTION_BITS+16:16];
    // bounds out of order collapse to a zero-width interval
    if (nhi < nlo) nhi = nlo;
    ivl_lo = nlo;
    ivl_hi = nhi;
    msg_symbols++;
    if (msg_symbols >= MESSAGE_LENGTH) begin
      mid  = ivl_lo + ((ivl_hi - ivl_lo) >> 1);
      code = 64'(mid);
      if (CODE_BITS <= FRACTION_BITS) begin
        code = code >> (FRACTION_BITS - CODE_BITS);
      end else begin
        code = code << (CODE_BITS - FRACTION_BITS);
      end
      if (CODE_BITS < 64) code = code & ((64'd1 << CODE_BITS) - 64'd1);
      due.codeword   = code[abe_pkg::CODE_W-1:0];
      due.bad_symbol = msg_bad;
      codes_due.push_back(due);
      restart_message();
    end
  endtask

  // channel monitor, sampled at the rising edge
  always @(posedge clk) begin
    code_word_t due;
    if (!rst_n) begin
      alphabet_reg = abe_pkg::ALPHABET_RESET;
      bound_reg    = abe_pkg::BOUND_RESET;
      restart_message();
      codes_due.delete();
    end else begin
      // configuration transfer
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == abe_pkg::REG_SYMBOL_COUNT) begin
          alphabet_reg = cfg_ch.data[abe_pkg::COUNT_W-1:0];
        end else begin
          bound_reg[cfg_ch.index] = cfg_ch.data;
        end
      end
      // symbol transfer
      if (sym_ch.valid && sym_ch.ready) begin
        narrow_interval(sym_ch.symbol_index);
        symbols_taken++;
      end
      // codeword transfer
      if (code_ch.valid && code_ch.ready) begin
        codes_taken++;
        if (code_ch.bad_symbol) flagged_codes++;
        if (codes_due.size() == 0) begin
          $display("%0t: unexpected codeword %h bad_symbol %b", $time,
                   code_ch.codeword, code_ch.bad_symbol);
          fail_count++;
        end else begin
          due = codes_due.pop_front();
          if (code_ch.codeword !== due.codeword) begin
            $display("%0t: codeword mismatch expected %h actual %h", $time,
                     due.codeword, code_ch.codeword);
            fail_count++;
          end
          if (code_ch.bad_symbol !== due.bad_symbol) begin
            $display("%0t: bad_symbol mismatch expected %b actual %b", $time,
                     due.bad_symbol, code_ch.bad_symbol);
            fail_count++;
          end
        end
      end
    end
    pending = codes_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the arithmetic block encoder
// Drives symbol messages in random bursts under several alphabet and bound
// settings, stalls the codeword channel on its own pattern and leaves all
// checking to the codeword checker instantiated beside the encoder.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MSG_LEN       = 8;
  localparam int CODE_LEN      = 32;
  localparam int FRAC_LEN      = 48;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 8;

  typedef enum {RECV_OPEN, RECV_TOGGLE, RECV_RANDOM, RECV_LONG} recv_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int pending;
  int symbols_taken;
  int codes_taken;
  int flagged_codes;

  int         cycle_count   = 0;
  int         alphabet_now  = int'(abe_pkg::ALPHABET_RESET);
  int         settings_used = 1;
  recv_mode_t recv_mode     = RECV_OPEN;
  int         recv_age      = 0;
  int         recv_hold     = 0;
  logic       recv_next;

  abe_sym_if  in_if ();
  abe_code_if out_if ();
  abe_cfg_if  cfg_if ();

  arithmetic_block_encoder_top #(
    .MESSAGE_LENGTH (MSG_LEN),
    .CODE_BITS      (CODE_LEN),
    .FRACTION_BITS  (FRAC_LEN)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  abe_code_checker #(
    .MESSAGE_LENGTH (MSG_LEN),
    .CODE_BITS      (CODE_LEN),
    .FRACTION_BITS  (FRAC_LEN)
  ) chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .sym_ch        (in_if),
    .code_ch       (out_if),
    .cfg_ch        (cfg_if),
    .fail_count    (fail_count),
    .pending       (pending),
    .symbols_taken (symbols_taken),
    .codes_taken   (codes_taken),
    .flagged_codes (flagged_codes)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codewords outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // codeword receiver: stall pattern changes mode when recv_age runs out
  always @(negedge clk) begin
    if (recv_age == 0) begin
      recv_mode = recv_mode_t'($urandom_range(0, 3));
      recv_age  = $urandom_range(50, 250);
    end
    recv_age--;
    case (recv_mode)
      RECV_OPEN:   recv_next = 1'b1;
      RECV_TOGGLE: recv_next = ~out_if.ready;
      RECV_RANDOM: recv_next = ($urandom_range(0, 3) != 0);
      default: begin
        if (recv_hold == 0) begin
          recv_next = ~out_if.ready;
          recv_hold = $urandom_range(1, 20);
        end else begin
          recv_next = out_if.ready;
          recv_hold--;
        end
      end
    endcase
    out_if.ready <= recv_next;
  end

  // one symbol transfer; valid stays high for a following symbol
  task automatic send_symbol(input logic [abe_pkg::SYM_W-1:0] sym);
    in_if.valid        <= 1'b1;
    in_if.symbol_index <= sym;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // eight symbols, most significant first
  task automatic send_message(input logic [MSG_LEN*abe_pkg::SYM_W-1:0] syms);
    for (int i = MSG_LEN - 1; i >= 0; i--) begin
      send_symbol(syms[i*abe_pkg::SYM_W +: abe_pkg::SYM_W]);
    end
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // hold the sender until every predicted codeword has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_transfer(input logic [abe_pkg::CFG_IDX_W-1:0] idx,
                              input logic [abe_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // write every register while the encoder is idle
  task automatic apply_setting(input logic [abe_pkg::CFG_DATA_W-1:0] count_word,
                               input abe_pkg::bound_set_t bounds);
    int c;
    drain_results();
    cfg_transfer(abe_pkg::REG_SYMBOL_COUNT, count_word);
    for (int k = 1; k <= 7; k++) begin
      cfg_transfer(abe_pkg::REG_BOUND_ONE + abe_pkg::CFG_IDX_W'(k - 1), bounds[k]);
    end
    cfg_if.valid <= 1'b0;
    c = int'(count_word[abe_pkg::COUNT_W-1:0]);
    if (c < int'(abe_pkg::ALPHABET_MIN)) c = int'(abe_pkg::ALPHABET_MIN);
    if (c > int'(abe_pkg::ALPHABET_MAX)) c = int'(abe_pkg::ALPHABET_MAX);
    alphabet_now = c;
    settings_used++;
  endtask

  // alphabet size word: mostly legal, sometimes any nibble, random upper bits
  function automatic logic [abe_pkg::CFG_DATA_W-1:0] random_count_word();
    logic [abe_pkg::CFG_DATA_W-1:0] w;
    w = abe_pkg::CFG_DATA_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 3) != 0) begin
      w[abe_pkg::COUNT_W-1:0] = abe_pkg::COUNT_W'($urandom_range(
          int'(abe_pkg::ALPHABET_MIN), int'(abe_pkg::ALPHABET_MAX)));
    end else begin
      w[abe_pkg::COUNT_W-1:0] = abe_pkg::COUNT_W'($urandom_range(0, 15));
    end
    return w;
  endfunction

  // bound sets: sorted, unordered, extreme or heavily skewed
  function automatic abe_pkg::bound_set_t random_bounds();
    abe_pkg::bound_set_t           b;
    int                            style;
    logic [abe_pkg::BOUND_W-1:0]   t;
    style = $urandom_range(0, 3);
    for (int k = 1; k <= 7; k++) b[k] = abe_pkg::BOUND_W'($urandom_range(0, 65535));
    case (style)
      0: begin
        for (int i = 1; i < 7; i++) begin
          for (int j = 1; j <= 7 - i; j++) begin
            if (b[j] > b[j+1]) begin
              t      = b[j];
              b[j]   = b[j+1];
              b[j+1] = t;
            end
          end
        end
      end
      2: begin
        for (int k = 1; k <= 7; k++) begin
          case ($urandom_range(0, 2))
            0:       b[k] = '0;
            1:       b[k] = '1;
            default: ;
          endcase
        end
      end
      3: begin
        for (int k = 1; k <= 7; k++) b[k] = abe_pkg::BOUND_W'(k);
      end
      default: ;
    endcase
    return b;
  endfunction

  // stimulus
  initial begin
    int burst_left;
    int gap_style;
    int phase_items;
    in_if.valid        = 1'b0;
    in_if.symbol_index = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration, extreme symbols
    send_message({3'd7, 3'd7, 3'd0, 3'd0, 3'd7, 3'd0, 3'd3, 3'd4});

    // three-symbol alphabet, bound one above bound two: symbol 1 collapses
    // the interval, symbols 3 and 7 clamp and flag the message
    apply_setting(16'hFFF3, {16'hE000, 16'hC000, 16'hA000, 16'h8000,
                             16'h6000, 16'h0000, 16'hFFFF});
    send_message({3'd0, 3'd3, 3'd1, 3'd2, 3'd7, 3'd1, 3'd0, 3'd2});

    // alphabet size zero acts as two; flag must be clear again
    apply_setting(16'h0000, abe_pkg::BOUND_RESET);
    send_message({3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd1});

    // random phases, each under its own setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       apply_setting(16'h000F, {7{16'hFFFF}});
        1:       apply_setting(16'hABC1, '0);
        default: apply_setting(random_count_word(), random_bounds());
      endcase
      gap_style   = (p == 2) ? 0 : $urandom_range(0, 2);
      phase_items = $urandom_range(105, 130);
      burst_left  = $urandom_range(1, 24);
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(0, 7) != 0) begin
          send_symbol(abe_pkg::SYM_W'($urandom_range(0, alphabet_now - 1)));
        end else begin
          send_symbol(abe_pkg::SYM_W'($urandom_range(0, 7)));
        end
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          case (gap_style)
            1:       pause_input($urandom_range(0, 3));
            2:       pause_input($urandom_range(1, 12));
            default: ;
          endcase
        end
        // sender waits mid-phase until every predicted codeword has arrived
        if (p == 3 && i == phase_items / 2) drain_results();
      end
    end

    drain_results();

    $display("covered %0d symbols and %0d codewords, %0d of them flagged bad_symbol,",
             symbols_taken, codes_taken, flagged_codes);
    $display("under %0d alphabet and bound settings with input gaps and output stalls",
             settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d codewords never seen", fail_count, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
